@@ rtl/bdpt_pkg.sv @@
// Types and constants shared by the button debounce / press timer block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdpt_pkg;

  localparam int unsigned TICK_W  = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned IDX_W   = 2;

  localparam logic [TICK_W-1:0] TICKS_RESET = 10'd40;

  typedef enum logic [1:0] {
    PH_LOW     = 2'd0,
    PH_RISING  = 2'd1,
    PH_HIGH    = 2'd2,
    PH_FALLING = 2'd3
  } phase_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               command;
    logic [LEVEL_W-1:0] levels;
    logic [IDX_W-1:0]   button_index;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0]  duration;
    logic               duration_valid;
    logic [LEVEL_W-1:0] debounced;
  } out_t;

  // per-lane strobes, already qualified by an accepted request
  typedef struct packed {
    logic sample;
    logic clear;
    logic raw;
  } lane_ctl_t;

  // lane state as it stands after the current request
  typedef struct packed {
    logic [TIME_W-1:0] duration;
    logic              valid;
    logic              debounced;
  } lane_out_t;

endpackage

`default_nettype wire

@@ rtl/bdpt_lane.sv @@
// One button lane: two-sample debounce FSM, press time capture, held duration.
// Depends on bdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpt_lane
  import bdpt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lane_ctl_t         ctl_i,
  input  wire logic [TIME_W-1:0] time_i,
  output lane_out_t              lane_o
);

  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] press_q, press_d;
  logic [TIME_W-1:0] held_q, held_d;
  logic              valid_q, valid_d;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (ctl_i.sample) begin
      unique case (phase_q)
        PH_LOW:     phase_d = ctl_i.raw ? PH_RISING : PH_LOW;
        PH_RISING:  phase_d = ctl_i.raw ? PH_HIGH : PH_LOW;
        PH_HIGH:    phase_d = ctl_i.raw ? PH_HIGH : PH_FALLING;
        PH_FALLING: phase_d = ctl_i.raw ? PH_HIGH : PH_LOW;
        default:    phase_d = PH_LOW;
      endcase
    end
  end

  // captures driven by the confirmed transitions
  always_comb begin
    press_d = press_q;
    held_d  = held_q;
    valid_d = valid_q;
    if (ctl_i.sample) begin
      unique case (phase_q)
        PH_RISING: begin
          if (ctl_i.raw) press_d = time_i;
        end
        PH_FALLING: begin
          if (!ctl_i.raw) begin
            held_d  = time_i - press_q;
            valid_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ctl_i.clear) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LOW;
      press_q <= '0;
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      press_q <= press_d;
      held_q  <= held_d;
      valid_q <= valid_d;
    end
  end

  assign lane_o.duration  = held_d;
  assign lane_o.valid     = valid_d;
  assign lane_o.debounced = (phase_d == PH_HIGH) || (phase_d == PH_FALLING);

endmodule

`default_nettype wire

@@ rtl/bdpt_merge.sv @@
// Merge stage: picks the selected lane, packs debounced levels, and holds the
// result in an output register backed by a skid register. Depends on bdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpt_merge
  import bdpt_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [IDX_W-1:0] sel_i,
  input  wire lane_out_t        lanes_i [NUM_BUTTONS],
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o
);

  localparam int unsigned DEB_LANES = (NUM_BUTTONS < LEVEL_W) ? NUM_BUTTONS : LEVEL_W;

  out_t result;
  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  // a missing button reports zero duration, not valid
  always_comb begin
    result = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if ({{(32-IDX_W){1'b0}}, sel_i} == 32'(b)) begin
        result.duration       = lanes_i[b].duration;
        result.duration_valid = lanes_i[b].valid;
      end
    end
    for (int b = 0; b < DEB_LANES; b++) begin
      result.debounced[b] = lanes_i[b].debounced;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept_i;
      skid_valid_q <= 1'b0;
    end else if (accept_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (accept_i) begin
      skid_q <= result;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/button_debounce_press_timer.sv @@
// Multi-button debouncer with press duration timer. Depends on bdpt_pkg,
// bdpt_lane and bdpt_merge.
// Results are registered; a skid register takes one result while the output
// is stalled. Throughput: one request per cycle while in_stall_o is low; on a
// sample request all button lanes update in the same cycle.
// Reset: all buttons low, times and durations zero, ticks_per_sample 40.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_timer
  import bdpt_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [TICK_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_data_o
);

  logic [TICK_W-1:0] ticks_q;
  logic [TIME_W-1:0] time_q;
  logic              accept;
  logic              do_sample;
  logic              do_clear;
  logic              full;
  lane_ctl_t         ctl   [NUM_BUTTONS];
  lane_out_t         lanes [NUM_BUTTONS];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;
  assign do_sample   = accept && (in_data_i.command == CMD_SAMPLE);
  assign do_clear    = accept && (in_data_i.command == CMD_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      time_q  <= '0;
    end else begin
      if (cfg_valid_i) ticks_q <= cfg_data_i;
      if (do_sample) time_q <= time_q + {{(TIME_W-TICK_W){1'b0}}, ticks_q};
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    assign ctl[b].sample = do_sample;
    assign ctl[b].clear  = do_clear &&
                           ({{(32-IDX_W){1'b0}}, in_data_i.button_index} == 32'(b));
    // buttons beyond the level field read as released
    if (b < LEVEL_W) begin : g_raw
      assign ctl[b].raw = in_data_i.levels[b];
    end else begin : g_noraw
      assign ctl[b].raw = 1'b0;
    end

    bdpt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[b]),
      .time_i (time_q),
      .lane_o (lanes[b])
    );
  end

  bdpt_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sel_i       (in_data_i.button_index),
    .lanes_i     (lanes),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
